FILE: design/linear_key_value_table_macros.svh
// Assertion macros shared by the checker of the key-value table.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lkv_pkg.sv
// Shared types and codes for the linear key-value table.
// No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int KEY_W      = 32;
  localparam int VAL_PORT_W = 32;
  localparam int COUNT_W    = 7;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

FILE: design/linear_key_value_table.sv
// Linear key-value table: packed, unsorted entries in one synchronous RAM.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel in_valid/in_ready carries func, key and value_in.
//   Result channel out_valid/out_ready carries status, value_out and
//   entry_count (the count after the operation). One result per request.
//   Load capacity_limit via capacity_limit_we only while idle; not enforced.
// Timing
//   One request at a time. Every request scans the RAM one entry a cycle
//   through its single read port until the key is found or all entries are
//   checked. A delete that hits then moves each later entry down one place,
//   one read and one write a cycle.
// Reset
//   rst clears the count to zero, the capacity to 64 and the result valid.
//   RAM contents are not cleared; only positions below the count are read.
// Stall
//   The result register holds while out_ready is low. The block takes the
//   next request meanwhile but finishes it only once the register is free.
module linear_key_value_table #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           capacity_limit_we,
  input  logic [lkv_pkg::COUNT_W-1:0]    capacity_limit,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lkv_pkg::FUNC_W-1:0]     func,
  input  logic signed [lkv_pkg::KEY_W-1:0] key,
  input  logic [lkv_pkg::VAL_PORT_W-1:0] value_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lkv_pkg::STATUS_W-1:0]   status,
  output logic [lkv_pkg::VAL_PORT_W-1:0] value_out,
  output logic [lkv_pkg::COUNT_W-1:0]    entry_count
);
  import lkv_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int EW   = KEY_W + VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [COUNT_W-1:0] cap;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      ptr, ptr_next;      // next address to read
  logic [AW-1:0]      chk, chk_next;      // position held in rd_data
  logic               chk_ok, chk_ok_next;
  logic [AW-1:0]      dst, dst_next;      // shift write position

  logic [FUNC_W-1:0]      req_func;
  logic [KEY_W-1:0]       req_key;
  logic [VALUE_WIDTH-1:0] req_val;

  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [VAL_PORT_W-1:0] res_value, res_value_next;

  logic hit, full, out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign hit      = chk_ok && (rd_data[VALUE_WIDTH +: KEY_W] == req_key);
  assign full     = (CMPW'(count) >= CMPW'(cap)) || (count >= CW'(DEPTH));

  // table RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    chk_next        = chk;
    chk_ok_next     = chk_ok;
    dst_next        = dst;
    count_next      = count;
    res_status_next = res_status;
    res_value_next  = res_value;
    rd_en           = 1'b0;
    rd_addr         = ptr[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = chk;
    wr_data         = {req_key, req_val};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next  = S_SCAN;
          ptr_next    = '0;
          chk_ok_next = 1'b0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status_next = ST_OK;
          res_value_next  = '0;
          state_next      = S_RESP;
          case (req_func)
            FUNC_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = chk;
            end
            FUNC_LOOKUP: begin
              res_value_next = VAL_PORT_W'(rd_data[VALUE_WIDTH-1:0]);
            end
            FUNC_DELETE: begin
              dst_next    = chk;
              ptr_next    = CW'(chk) + CW'(1);
              chk_ok_next = 1'b0;
              state_next  = S_SHIFT;
            end
            default: begin
              res_status_next = ST_MISS;
            end
          endcase
        end else if (!chk_ok && ptr >= count) begin
          // whole table checked, no match
          res_value_next = '0;
          state_next     = S_RESP;
          if (req_func == FUNC_INSERT) begin
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en           = 1'b1;
              wr_addr         = count[AW-1:0];
              count_next      = count + CW'(1);
              res_status_next = ST_OK;
            end
          end else begin
            res_status_next = ST_MISS;
          end
        end else begin
          rd_en       = (ptr < count);
          chk_next    = ptr[AW-1:0];
          chk_ok_next = (ptr < count);
          if (ptr < count) begin
            ptr_next = ptr + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        // read ptr while writing the entry read last cycle one place down
        if (chk_ok) begin
          wr_en    = 1'b1;
          wr_addr  = dst;
          wr_data  = rd_data;
          dst_next = dst + AW'(1);
        end
        if (ptr < count) begin
          rd_en       = 1'b1;
          ptr_next    = ptr + CW'(1);
          chk_ok_next = 1'b1;
        end else begin
          chk_ok_next = 1'b0;
        end
        if (!chk_ok && ptr >= count) begin
          count_next = count - CW'(1);
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CAP_RESET;
      chk_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      chk_ok <= chk_ok_next;
      if (capacity_limit_we) begin
        cap <= capacity_limit;
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    chk        <= chk_next;
    dst        <= dst_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (in_valid && in_ready) begin
      req_func <= func;
      req_key  <= $unsigned(key);
      req_val  <= VALUE_WIDTH'(value_in);
    end
    if (state == S_RESP && out_free) begin
      status      <= res_status;
      value_out   <= res_value;
      entry_count <= COUNT_W'(count);
    end
  end

endmodule

FILE: design/lkv_checker.sv
// Port-level checks for the linear key-value table, bound to the top level.
// Depends on lkv_pkg and linear_key_value_table_macros.svh.
`timescale 1ns / 1ps
`include "linear_key_value_table_macros.svh"

module lkv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lkv_pkg::STATUS_W-1:0]   status,
  input logic [lkv_pkg::VAL_PORT_W-1:0] value_out,
  input logic [lkv_pkg::COUNT_W-1:0]    entry_count
);
  import lkv_pkg::*;

  // a held result keeps its fields
  `LKV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(value_out) && $stable(entry_count), "result changed while stalled")

  // one request at a time: ready drops right after an item is taken
  `LKV_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready stayed high after accept")

  // no result straight out of reset
  `LKV_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid, "result valid right after reset")

  // only a successful lookup returns a value
  `LKV_ASSERT_NOW(a_value_zero, out_valid && status != ST_OK, value_out == '0, "value on a failed request")

endmodule

bind linear_key_value_table lkv_checker u_lkv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .value_out   (value_out),
  .entry_count (entry_count)
);

FILE: sim/linear_key_value_table_tb.sv
// Self-checking testbench for linear_key_value_table: directed and random requests,
// with results checked in order against a table model kept inside the bench.
// Depends on lkv_pkg and the linear_key_value_table RTL.
`timescale 1ns / 1ps

module linear_key_value_table_tb;
  import lkv_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]     op;
    logic [KEY_W-1:0]      k;
    logic [VAL_PORT_W-1:0] v;
  } kv_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   st;
    logic [VAL_PORT_W-1:0] val;
    logic [COUNT_W-1:0]    cnt;
  } kv_rsp_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      capacity_limit_we = 1'b0;
  logic [COUNT_W-1:0]        capacity_limit = CAP_RESET;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func = FUNC_LOOKUP;
  logic signed [KEY_W-1:0]   key = '0;
  logic [VAL_PORT_W-1:0]     value_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [VAL_PORT_W-1:0]     value_out;
  logic [COUNT_W-1:0]        entry_count;

  // model of the table contents
  logic [KEY_W-1:0]      kv_keys [TBL_DEPTH];
  logic [VAL_PORT_W-1:0] kv_vals [TBL_DEPTH];
  int                    kv_count = 0;
  int                    cap_reg = CAP_RESET;

  kv_req_t     pending_reqs [$];
  kv_rsp_t     expect_q [$];
  logic [KEY_W-1:0] key_pool [$];
  kv_req_t     nxt_req;
  kv_rsp_t     exp_rsp;
  bit          req_fire = 1'b0;
  bit          rsp_fire = 1'b0;
  bit          quiet = 1'b0;
  bit          long_hold_done = 1'b0;
  int          send_wait = 0;
  int          stall_left = 0;
  int          results_seen = 0;
  int          errors = 0;

  linear_key_value_table DUT (
    .clk               (clk),
    .rst               (rst),
    .capacity_limit_we (capacity_limit_we),
    .capacity_limit    (capacity_limit),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .key               (key),
    .value_in          (value_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .value_out         (value_out),
    .entry_count       (entry_count)
  );

  always #5 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic kv_rsp_t kv_apply(input kv_req_t r);
    kv_rsp_t res;
    int pos;
    int lim;
    res.st = ST_MISS;
    res.val = '0;
    pos = kv_count;
    for (int i = kv_count - 1; i >= 0; i--) begin
      if (kv_keys[i] == r.k) pos = i;
    end
    lim = (cap_reg < TBL_DEPTH) ? cap_reg : TBL_DEPTH;
    case (r.op)
      FUNC_INSERT: begin
        if (pos < kv_count) begin
          kv_vals[pos] = r.v;
          res.st = ST_OK;
        end else if (kv_count >= lim) begin
          res.st = ST_FULL;
        end else begin
          kv_keys[kv_count] = r.k;
          kv_vals[kv_count] = r.v;
          kv_count++;
          res.st = ST_OK;
        end
      end
      FUNC_LOOKUP: begin
        if (pos < kv_count) begin
          res.val = kv_vals[pos];
          res.st = ST_OK;
        end
      end
      FUNC_DELETE: begin
        if (pos < kv_count) begin
          for (int j = pos; j + 1 < kv_count; j++) begin
            kv_keys[j] = kv_keys[j + 1];
            kv_vals[j] = kv_vals[j + 1];
          end
          kv_count--;
          res.st = ST_OK;
        end
      end
      default: ;
    endcase
    res.cnt = COUNT_W'(kv_count);
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt_req = pending_reqs.pop_front();
        func <= nxt_req.op;
        key <= nxt_req.k;
        value_in <= nxt_req.v;
        in_valid <= 1'b1;
        send_wait = quiet ? 0 : pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side back-pressure, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      long_hold_done = 1'b1;
      stall_left = 399;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = pick_idle();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    req_fire = in_valid && in_ready;
    rsp_fire = out_valid && out_ready;
    if (!rst) begin
      if (capacity_limit_we) cap_reg = capacity_limit;
      if (rsp_fire) begin
        results_seen++;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d value %h count %0d",
                   $time, status, value_out, entry_count);
          errors++;
        end else begin
          exp_rsp = expect_q.pop_front();
          if (status !== exp_rsp.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.st, status);
            errors++;
          end
          if (value_out !== exp_rsp.val) begin
            $display("%0t: value_out expected %h actual %h", $time, exp_rsp.val, value_out);
            errors++;
          end
          if (entry_count !== exp_rsp.cnt) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_rsp.cnt, entry_count);
            errors++;
          end
        end
      end
      if (req_fire) expect_q.push_back(kv_apply('{func, key, value_in}));
    end
  end

  task automatic push_req(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [VAL_PORT_W-1:0] v);
    pending_reqs.push_back('{op, k, v});
  endtask

  // sender holds until every result is back
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [COUNT_W-1:0] cap);
    capacity_limit_we <= 1'b1;
    capacity_limit <= cap;
    @(negedge clk);
    capacity_limit_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] cap, input int n, input int pool_n,
                           input int w_ins, input int w_look, input int w_del);
    int r;
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [VAL_PORT_W-1:0] v;
    drain();
    set_capacity(cap);
    key_pool.delete();
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7FFF_FFFF);
    for (int i = 2; i < pool_n; i++) key_pool.push_back($urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = FUNC_INSERT;
      else if (r < w_ins + w_look) op = FUNC_LOOKUP;
      else if (r < w_ins + w_look + w_del) op = FUNC_DELETE;
      else op = FUNC_UNUSED;
      // a few keys outside the pool keep misses and fresh inserts coming
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      r = $urandom_range(0, 9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      push_req(op, k, v);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, extreme keys and values, update, shifts on delete
    push_req(FUNC_LOOKUP, 32'd5, 32'hDEAD_BEEF);
    push_req(FUNC_DELETE, 32'd5, '0);
    push_req(FUNC_UNUSED, 32'd5, '1);
    push_req(FUNC_INSERT, 32'h8000_0000, '0);
    push_req(FUNC_INSERT, 32'h7FFF_FFFF, '1);
    push_req(FUNC_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    push_req(FUNC_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    push_req(FUNC_LOOKUP, 32'h8000_0000, '1);
    push_req(FUNC_LOOKUP, 32'h7FFF_FFFF, '0);
    push_req(FUNC_LOOKUP, 32'hFFFF_FFFF, '0);
    push_req(FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
    push_req(FUNC_LOOKUP, 32'h0000_0000, '0);
    push_req(FUNC_DELETE, 32'h7FFF_FFFF, '0);
    push_req(FUNC_LOOKUP, 32'hFFFF_FFFF, '0);
    push_req(FUNC_LOOKUP, 32'h7FFF_FFFF, '0);
    push_req(FUNC_DELETE, 32'h8000_0000, '0);
    push_req(FUNC_DELETE, 32'hFFFF_FFFF, '0);
    push_req(FUNC_UNUSED, 32'h0000_0000, '1);
    push_req(FUNC_LOOKUP, 32'h0000_0000, '0);
    push_req(FUNC_DELETE, 32'h0000_0000, '0);

    // small capacity, then capacity dropped below the count
    drain();
    set_capacity(7'd2);
    push_req(FUNC_INSERT, 32'd1, 32'd11);
    push_req(FUNC_INSERT, 32'd2, 32'd22);
    push_req(FUNC_INSERT, 32'd3, 32'd33);
    drain();
    set_capacity(7'd0);
    push_req(FUNC_INSERT, 32'd1, 32'd111);
    push_req(FUNC_INSERT, 32'd4, 32'd44);
    push_req(FUNC_DELETE, 32'd2, '0);
    push_req(FUNC_INSERT, 32'd5, 32'd55);
    push_req(FUNC_LOOKUP, 32'd1, '0);

    // random phases: capacity above depth, tiny, zero, mid-range, full depth
    run_phase(7'd127, 110, 90, 70, 15, 10);
    quiet = 1'b1;
    run_phase(7'd5, 90, 12, 40, 30, 25);
    quiet = 1'b0;
    run_phase(7'd64, 100, 80, 25, 35, 35);
    run_phase(7'd0, 60, 12, 40, 30, 25);
    quiet = 1'b1;
    run_phase(7'd1, 70, 6, 40, 30, 25);
    quiet = 1'b0;
    run_phase(7'd33, 100, 50, 40, 30, 25);
    run_phase(7'd64, 100, 70, 55, 20, 20);
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
